// File: rtl/rwb_pkg.sv
`default_nettype none

package rwb_pkg;

  // Image geometry defaults
  localparam int unsigned DefWidth  = 128;
  localparam int unsigned DefHeight = 64;

  // Register map
  localparam logic [1:0] RegMaxRange = 2'd0;
  localparam logic [1:0] RegMarkHalf = 2'd1;
  localparam logic [1:0] RegMarkCols = 2'd2;

  localparam logic [15:0] MaxRangeRst = 16'd10000;
  localparam logic [4:0]  MarkHalfRst = 5'd8;
  localparam logic [4:0]  MarkColsRst = 5'd5;

  // Function codes of an input transaction
  localparam logic [1:0] FuncPush  = 2'd0;
  localparam logic [1:0] FuncRead  = 2'd1;
  localparam logic [1:0] FuncClear = 2'd2;

  // Row code for "no mark" and every non-push result
  localparam logic [6:0] NoRow = 7'd64;

  // Row division: numerator width and quotient bits
  localparam int unsigned NumW  = 24;
  localparam int unsigned QBits = 7;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    OP_MARK_NONE,
    OP_MARK_TOP,
    OP_MARK_DIV,
    OP_READ,
    OP_READ_ZERO,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] diff;
    logic [2:0]  page_sel;
    logic [6:0]  column_sel;
  } cmd_t;

  typedef struct packed {
    logic [15:0] max_range_mm;
    logic [4:0]  mark_half_rows;
    logic [4:0]  mark_cols;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_BAND,
    ST_WRITE,
    ST_READ
  } state_e;

endpackage

`default_nettype wire

// File: rtl/rwb_front.sv
`default_nettype none

module rwb_front #(
  parameter int unsigned WIDTH  = rwb_pkg::DefWidth,
  parameter int unsigned HEIGHT = rwb_pkg::DefHeight
) (
  input  wire logic               [1:0]  func_i,
  input  wire logic signed        [15:0] range_mm_i,
  input  wire logic               [2:0]  page_sel_i,
  input  wire logic               [6:0]  column_sel_i,
  input  wire rwb_pkg::cfg_t             cfg_i,
  output rwb_pkg::cmd_t                  cmd_o
);

  localparam int unsigned Pages = (HEIGHT + 7) / 8;

  logic range_pos;
  logic range_top;
  logic read_ok;

  assign range_pos = !range_mm_i[15] && (range_mm_i != 16'sd0);
  assign range_top = unsigned'(range_mm_i) >= cfg_i.max_range_mm;
  assign read_ok   = ({2'b00, column_sel_i} < 9'(WIDTH)) && ({1'b0, page_sel_i} < 4'(Pages));

  // Classify the transaction so the back end only executes
  always_comb begin
    cmd_o.diff       = cfg_i.max_range_mm - unsigned'(range_mm_i);
    cmd_o.page_sel   = page_sel_i;
    cmd_o.column_sel = column_sel_i;
    unique case (func_i)
      rwb_pkg::FuncPush: begin
        if (!range_pos) begin
          cmd_o.op = rwb_pkg::OP_MARK_NONE;
        end else if (range_top) begin
          cmd_o.op = rwb_pkg::OP_MARK_TOP;
        end else begin
          cmd_o.op = rwb_pkg::OP_MARK_DIV;
        end
      end
      rwb_pkg::FuncRead:  cmd_o.op = read_ok ? rwb_pkg::OP_READ : rwb_pkg::OP_READ_ZERO;
      rwb_pkg::FuncClear: cmd_o.op = rwb_pkg::OP_CLEAR;
      default:            cmd_o.op = rwb_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rwb_queue.sv
`default_nettype none

module rwb_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire rwb_pkg::cmd_t wdata_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output logic               valid_o,
  output rwb_pkg::cmd_t      rdata_o
);

  localparam int unsigned Depth = rwb_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rwb_pkg::cmd_t entry_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr;
  logic            do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = entry_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_wr) - CntW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rwb_back.sv
`default_nettype none

module rwb_back #(
  parameter int unsigned WIDTH  = rwb_pkg::DefWidth,
  parameter int unsigned HEIGHT = rwb_pkg::DefHeight
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rwb_pkg::cfg_t cfg_i,
  input  wire logic          head_valid_i,
  input  wire rwb_pkg::cmd_t head_i,
  output logic               head_pop_o,
  output logic               res_valid_o,
  output logic [7:0]         res_byte_o,
  output logic [6:0]         res_row_o,
  input  wire logic          res_pop_i
);

  localparam int unsigned AddrW = $clog2(WIDTH);
  localparam int unsigned CntW  = $clog2(WIDTH + 1);
  localparam int unsigned NumW  = rwb_pkg::NumW;
  localparam int unsigned QBits = rwb_pkg::QBits;
  localparam int unsigned BitW  = $clog2(QBits);

  rwb_pkg::state_e state_q, state_d;
  rwb_pkg::cmd_t   cmd_q, cmd_d;

  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic [AddrW-1:0]  waddr_q, waddr_d;
  logic [CntW-1:0]   wcnt_q, wcnt_d;
  logic [NumW-1:0]   rem_q, rem_d;
  logic [16:0]       den_q, den_d;
  logic [BitW-1:0]   bit_q, bit_d;
  logic [6:0]        row_q, row_d;
  logic [HEIGHT-1:0] col_q, col_d;
  logic              res_valid_q, res_valid_d;
  logic [7:0]        res_byte_q, res_byte_d;
  logic [6:0]        res_row_q, res_row_d;
  logic [WIDTH-1:0]  valid_q;

  logic [HEIGHT-1:0] mem_q [WIDTH];
  logic [HEIGHT-1:0] rdata_q;
  logic              rvalid_q;

  logic              mem_we;
  logic              clear_all;
  logic [AddrW-1:0]  ptr_inc;
  logic [AddrW:0]    rsum;
  logic [AddrW-1:0]  raddr;
  logic [NumW-1:0]   den_sh;
  logic              ge;
  logic [6:0]        row_clip;
  logic [6:0]        lo;
  logic [6:0]        hi_sum;
  logic [6:0]        hi;
  logic [HEIGHT-1:0] ones;
  logic [CntW-1:0]   kval;
  logic [63:0]       rpad;

  assign ptr_inc = (ptr_q == AddrW'(WIDTH - 1)) ? '0 : ptr_q + 1'b1;

  // Screen column to store index, wrapped once
  assign rsum  = (AddrW+1)'(ptr_q) + (AddrW+1)'(head_i.column_sel);
  assign raddr = (rsum >= (AddrW+1)'(WIDTH)) ? AddrW'(rsum - (AddrW+1)'(WIDTH))
                                             : rsum[AddrW-1:0];

  assign den_sh = NumW'(den_q) << bit_q;
  assign ge     = rem_q >= den_sh;

  assign row_clip = (row_q >= 7'(HEIGHT)) ? 7'(HEIGHT - 1) : row_q;
  assign lo       = (row_clip > {2'b00, cfg_i.mark_half_rows})
                    ? row_clip - {2'b00, cfg_i.mark_half_rows} : 7'd0;
  assign hi_sum   = row_clip + {2'b00, cfg_i.mark_half_rows};
  assign hi       = (hi_sum > 7'(HEIGHT - 1)) ? 7'(HEIGHT - 1) : hi_sum;
  assign ones     = '1;

  assign kval = (cfg_i.mark_cols == 5'd0) ? CntW'(1)
              : ((CntW'(cfg_i.mark_cols) > CntW'(WIDTH)) ? CntW'(WIDTH)
                                                        : CntW'(cfg_i.mark_cols));

  assign rpad = rvalid_q ? 64'(rdata_q) : 64'd0;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    ptr_d       = ptr_q;
    waddr_d     = waddr_q;
    wcnt_d      = wcnt_q;
    rem_d       = rem_q;
    den_d       = den_q;
    bit_d       = bit_q;
    row_d       = row_q;
    col_d       = col_q;
    res_valid_d = res_valid_q && !res_pop_i;
    res_byte_d  = res_byte_q;
    res_row_d   = res_row_q;
    head_pop_o  = 1'b0;
    mem_we      = 1'b0;
    clear_all   = 1'b0;

    unique case (state_q)
      rwb_pkg::ST_IDLE: begin
        if (head_valid_i && !res_valid_q) begin
          head_pop_o = 1'b1;
          cmd_d      = head_i;
          unique case (head_i.op)
            rwb_pkg::OP_MARK_NONE: begin
              ptr_d   = ptr_inc;
              waddr_d = ptr_q;
              row_d   = rwb_pkg::NoRow;
              col_d   = '0;
              wcnt_d  = '0;
              state_d = rwb_pkg::ST_WRITE;
            end
            rwb_pkg::OP_MARK_TOP: begin
              ptr_d   = ptr_inc;
              waddr_d = ptr_q;
              row_d   = 7'd0;
              state_d = rwb_pkg::ST_BAND;
            end
            rwb_pkg::OP_MARK_DIV: begin
              ptr_d   = ptr_inc;
              waddr_d = ptr_q;
              state_d = rwb_pkg::ST_MUL;
            end
            rwb_pkg::OP_READ: begin
              state_d = rwb_pkg::ST_READ;
            end
            rwb_pkg::OP_CLEAR: begin
              clear_all   = 1'b1;
              res_valid_d = 1'b1;
              res_byte_d  = 8'd0;
              res_row_d   = rwb_pkg::NoRow;
            end
            rwb_pkg::OP_READ_ZERO, rwb_pkg::OP_NOP: begin
              res_valid_d = 1'b1;
              res_byte_d  = 8'd0;
              res_row_d   = rwb_pkg::NoRow;
            end
            default: ;
          endcase
        end
      end
      rwb_pkg::ST_MUL: begin
        rem_d   = NumW'({cmd_q.diff, 1'b0}) * NumW'(HEIGHT - 1) + NumW'(cfg_i.max_range_mm);
        den_d   = {cfg_i.max_range_mm, 1'b0};
        row_d   = 7'd0;
        bit_d   = BitW'(QBits - 1);
        state_d = rwb_pkg::ST_DIV;
      end
      rwb_pkg::ST_DIV: begin
        // One quotient bit per cycle, restoring
        if (ge) begin
          rem_d = rem_q - den_sh;
        end
        row_d = {row_q[5:0], ge};
        if (bit_q == '0) begin
          state_d = rwb_pkg::ST_BAND;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      rwb_pkg::ST_BAND: begin
        row_d   = row_clip;
        col_d   = (ones << lo) & (ones >> (7'(HEIGHT - 1) - hi));
        wcnt_d  = '0;
        state_d = rwb_pkg::ST_WRITE;
      end
      rwb_pkg::ST_WRITE: begin
        mem_we  = 1'b1;
        wcnt_d  = wcnt_q + 1'b1;
        waddr_d = (waddr_q == '0) ? AddrW'(WIDTH - 1) : waddr_q - 1'b1;
        if (wcnt_q == kval - 1'b1) begin
          res_valid_d = 1'b1;
          res_byte_d  = 8'd0;
          res_row_d   = row_q;
          state_d     = rwb_pkg::ST_IDLE;
        end
      end
      rwb_pkg::ST_READ: begin
        res_valid_d = 1'b1;
        res_byte_d  = rpad[{cmd_q.page_sel, 3'b000} +: 8];
        res_row_d   = rwb_pkg::NoRow;
        state_d     = rwb_pkg::ST_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rwb_pkg::ST_IDLE;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      res_valid_q <= res_valid_d;
      if (clear_all) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[waddr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    waddr_q    <= waddr_d;
    wcnt_q     <= wcnt_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    bit_q      <= bit_d;
    row_q      <= row_d;
    col_q      <= col_d;
    res_byte_q <= res_byte_d;
    res_row_q  <= res_row_d;
  end

  // Column store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr_q] <= col_q;
    end
    rdata_q  <= mem_q[raddr];
    rvalid_q <= valid_q[raddr];
  end

  assign res_valid_o = res_valid_q;
  assign res_byte_o  = res_byte_q;
  assign res_row_o   = res_row_q;

endmodule

`default_nettype wire

// File: rtl/range_waterfall_bitmap_unit.sv
// Sequence: a push through the divider passes the multiply, divide and band states,
//   a push at or above max range the band state only, a push without a mark neither;
//   every push then writes k columns, k = mark_cols clipped to 1..WIDTH.
// Throughput: one transaction at a time in the back end; the 7-step divider and
//   the single write port of the column store (k writes) set the push rate.
// Reset: asynchronous, active low; registers return to defaults, scroll pointer
//   to zero, the image reads all zero, command queue and result register empty.
`default_nettype none

module range_waterfall_bitmap_unit #(
  parameter int unsigned WIDTH  = rwb_pkg::DefWidth,
  parameter int unsigned HEIGHT = rwb_pkg::DefHeight
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic        [1:0]  cfg_idx_i,
  input  wire logic        [15:0] cfg_wdata_i,
  // Input side
  input  wire logic               push,
  output logic                    full,
  input  wire logic        [1:0]  func_i,
  input  wire logic signed [15:0] range_mm_i,
  input  wire logic        [2:0]  page_sel_i,
  input  wire logic        [6:0]  column_sel_i,
  // Result side
  output logic                    empty,
  input  wire logic               pop,
  output logic             [7:0]  read_byte_o,
  output logic             [6:0]  placed_row_o
);

  rwb_pkg::cfg_t cfg_q, cfg_d;
  rwb_pkg::cmd_t front_cmd;
  rwb_pkg::cmd_t head_cmd;
  logic          head_valid;
  logic          head_pop;
  logic          res_valid;

  // Configuration registers; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rwb_pkg::RegMaxRange: cfg_d.max_range_mm   = cfg_wdata_i;
        rwb_pkg::RegMarkHalf: cfg_d.mark_half_rows = cfg_wdata_i[4:0];
        rwb_pkg::RegMarkCols: cfg_d.mark_cols      = cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_range_mm   <= rwb_pkg::MaxRangeRst;
      cfg_q.mark_half_rows <= rwb_pkg::MarkHalfRst;
      cfg_q.mark_cols      <= rwb_pkg::MarkColsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify each transaction as it is accepted
  rwb_front #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_front (
    .func_i      (func_i),
    .range_mm_i  (range_mm_i),
    .page_sel_i  (page_sel_i),
    .column_sel_i(column_sel_i),
    .cfg_i       (cfg_q),
    .cmd_o       (front_cmd)
  );

  // Decoupling queue: the front keeps accepting while the back end works, until it is full
  rwb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (push),
    .wdata_i(front_cmd),
    .full_o (full),
    .rd_i   (head_pop),
    .valid_o(head_valid),
    .rdata_o(head_cmd)
  );

  // Back end: divider, band builder, column writes, reads, clear
  rwb_back #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_valid_i(head_valid),
    .head_i      (head_cmd),
    .head_pop_o  (head_pop),
    .res_valid_o (res_valid),
    .res_byte_o  (read_byte_o),
    .res_row_o   (placed_row_o),
    .res_pop_i   (pop)
  );

  assign empty = !res_valid;

  // A placed row is either the no-mark code or a row on the screen
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (placed_row_o == rwb_pkg::NoRow || placed_row_o < 7'(HEIGHT)))
    else $error("placed row off screen");

  // Only reads return image bytes, and reads never place a row
  a_read_no_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && read_byte_o != 8'd0) |-> placed_row_o == rwb_pkg::NoRow)
    else $error("nonzero byte with a placed row");

  // Nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result present after reset");

endmodule

`default_nettype wire
